>>> hw/rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // ring position of base plus offset, offset at most DEPTH - 1
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cdq_ram.sv
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/circular_deque.sv
`default_nettype none

// Double-ended queue of signed 32-bit values held in a DEPTH-entry ring RAM
// with a head pointer and an item count. A push gives one status item
// (overflow when full). A pop reads the RAM and loads the value into the
// output register once free; input waits till then. A list streams every
// stored value front to back, one per cycle from the single RAM read port
// unless the output stalls, with last set on the back item; an empty queue
// gives one empty-status item for a pop or a list. Codes 5 to 7 are taken and
// ignored. A stalled result holds in the output register and holds off input.

module circular_deque (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cdq_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cdq_pkg::out_item_t       out_item
);

  import cdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] list_pos_r, list_pos_nxt;
  logic [CNT_W-1:0] list_rem_r, list_rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             out_free;
  logic             in_accept;
  logic             full;
  logic             empty;
  logic             load;
  logic [IDX_W-1:0] head_dec;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_data;

  cdq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item.value_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_dec  = ring_add(head_r, CNT_W'(DEPTH - 1));

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    list_pos_nxt = list_pos_r;
    list_rem_nxt = list_rem_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    load         = 1'b0;
    out_item_nxt = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_item_nxt.value_out = '0;
          out_item_nxt.status    = ST_OK;
          out_item_nxt.last      = 1'b1;
          unique case (in_item.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                out_item_nxt.status = ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (in_item.command == CMD_PUSH_FRONT) begin
                  wr_addr  = head_dec;
                  head_nxt = head_dec;
                end else begin
                  wr_addr = ring_add(head_r, count_r);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (empty) begin
                load                = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_POP;
                if (in_item.command == CMD_POP_FRONT) begin
                  head_nxt = ring_add(head_r, CNT_W'(1));
                end else begin
                  rd_addr = ring_add(head_r, count_r - CNT_W'(1));
                end
              end
            end
            CMD_LIST: begin
              if (empty) begin
                load                = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                list_pos_nxt = ring_add(head_r, CNT_W'(1));
                list_rem_nxt = count_r;
                state_nxt    = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          load                   = 1'b1;
          out_item_nxt.value_out = rd_data;
          out_item_nxt.status    = ST_OK;
          out_item_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          load                   = 1'b1;
          out_item_nxt.value_out = rd_data;
          out_item_nxt.status    = ST_OK;
          out_item_nxt.last      = (list_rem_r == CNT_W'(1));
          if (list_rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = list_pos_r;
            list_pos_nxt = ring_add(list_pos_r, CNT_W'(1));
            list_rem_nxt = list_rem_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_pos_r <= list_pos_nxt;
    list_rem_r <= list_rem_nxt;
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> hw/rtl/cdq_chk.sv
`default_nettype none

module cdq_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire cdq_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire cdq_pkg::out_item_t out_item
);

  import cdq_pkg::*;

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
  else $error("stalled result item changed");

  // only list items are non-final, and they carry ok
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> out_item.status == ST_OK)
  else $error("non-final item with error status");

  // error items carry a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.value_out == '0)
  else $error("error item with nonzero value");

  // no new command while a list is still streaming
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> in_stall)
  else $error("input taken during list");

  // a taken push answers on the next cycle with a single zero-value item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_item.command == CMD_PUSH_FRONT || in_item.command == CMD_PUSH_BACK)
    |=> out_valid && out_item.last && out_item.value_out == '0)
  else $error("push item missing");

endmodule

bind circular_deque cdq_chk u_cdq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
